FILE: hdl/edd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine package
// Shared types and fixed constants for the systolic edit distance engine.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int SYM_W    = 8;
  localparam int DIST_W   = 9;
  localparam int DIST_MAX = 511;

  typedef struct packed {
    logic valid;
    logic upd;
    logic fin;
  } ctl_t;

  typedef struct packed {
    logic init;
    logic wr;
  } bcast_t;

endpackage
`default_nettype wire

FILE: hdl/edd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance cell
// Holds one symbol of the first string and one entry of the cost row, and
// updates that entry as each second-string symbol passes by.
// ----------------------------------------------------------------------------
module edd_cell #(
  parameter int IDX = 1,
  parameter int LW  = 9,
  parameter int CW  = 9,
  parameter int SW  = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire edd_pkg::bcast_t bc,
  input  wire logic [LW-1:0]  wr_idx,
  input  wire logic [SW-1:0]  wr_sym,
  input  wire logic [LW-1:0]  end_len,
  input  wire edd_pkg::ctl_t  in_ctl,
  input  wire logic [SW-1:0]  in_sym,
  input  wire logic [CW-1:0]  in_cost,
  input  wire logic [CW-1:0]  in_prev,
  input  wire logic [CW-1:0]  in_res,
  output edd_pkg::ctl_t       out_ctl,
  output logic [SW-1:0]       out_sym,
  output logic [CW-1:0]       out_cost,
  output logic [CW-1:0]       out_prev,
  output logic [CW-1:0]       out_res
);

  edd_pkg::ctl_t ctl_r;
  logic [SW-1:0] sym_mem_r;
  logic [SW-1:0] sym_r;
  logic [CW-1:0] cost_r;
  logic [CW-1:0] cost_nxt;
  logic [CW-1:0] prev_r;
  logic [CW-1:0] res_r;
  logic [CW-1:0] res_nxt;
  logic [CW-1:0] up_c;
  logic [CW-1:0] left_c;
  logic [CW-1:0] diag_c;
  logic [CW-1:0] min_c;
  logic          apply;
  logic          hit;

  assign apply  = in_ctl.valid && in_ctl.upd;
  assign hit    = (end_len == LW'(IDX));
  assign up_c   = cost_r + CW'(1);
  assign left_c = in_cost + CW'(1);
  assign diag_c = in_prev + ((sym_mem_r == in_sym) ? CW'(0) : CW'(1));

  always_comb begin
    min_c = (up_c < left_c) ? up_c : left_c;
    if (diag_c < min_c) begin
      min_c = diag_c;
    end
    cost_nxt = apply ? min_c : cost_r;
    res_nxt  = (in_ctl.valid && hit) ? cost_nxt : in_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (bc.init) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (bc.wr && (wr_idx == LW'(IDX - 1))) begin
      sym_mem_r <= wr_sym;
    end
    if (bc.init) begin
      cost_r <= CW'(IDX);
    end else begin
      cost_r <= cost_nxt;
    end
    sym_r  <= in_sym;
    prev_r <= cost_r;
    res_r  <= res_nxt;
  end

  assign out_ctl  = ctl_r;
  assign out_sym  = sym_r;
  assign out_cost = cost_r;
  assign out_prev = prev_r;
  assign out_res  = res_r;

endmodule
`default_nettype wire

FILE: hdl/edd_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance cell chain
// A row of cells, one per first-string position, with each item's wavefront
// moving one cell per cycle toward the end of the row.
// ----------------------------------------------------------------------------
module edd_chain #(
  parameter int MAX_LEN = 256,
  parameter int LW      = 9,
  parameter int CW      = 9,
  parameter int SW      = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire edd_pkg::bcast_t bc,
  input  wire logic [LW-1:0]   wr_idx,
  input  wire logic [SW-1:0]   wr_sym,
  input  wire logic [LW-1:0]   end_len,
  input  wire edd_pkg::ctl_t   src_ctl,
  input  wire logic [SW-1:0]   src_sym,
  input  wire logic [CW-1:0]   src_cost,
  input  wire logic [CW-1:0]   src_prev,
  input  wire logic [CW-1:0]   src_res,
  output edd_pkg::ctl_t        end_ctl,
  output logic [CW-1:0]        end_res
);

  edd_pkg::ctl_t ctl_w  [0:MAX_LEN];
  logic [SW-1:0] sym_w  [0:MAX_LEN];
  logic [CW-1:0] cost_w [0:MAX_LEN];
  logic [CW-1:0] prev_w [0:MAX_LEN];
  logic [CW-1:0] res_w  [0:MAX_LEN];

  assign ctl_w[0]  = src_ctl;
  assign sym_w[0]  = src_sym;
  assign cost_w[0] = src_cost;
  assign prev_w[0] = src_prev;
  assign res_w[0]  = src_res;

  for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
    edd_cell #(
      .IDX (i),
      .LW  (LW),
      .CW  (CW),
      .SW  (SW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bc       (bc),
      .wr_idx   (wr_idx),
      .wr_sym   (wr_sym),
      .end_len  (end_len),
      .in_ctl   (ctl_w[i-1]),
      .in_sym   (sym_w[i-1]),
      .in_cost  (cost_w[i-1]),
      .in_prev  (prev_w[i-1]),
      .in_res   (res_w[i-1]),
      .out_ctl  (ctl_w[i]),
      .out_sym  (sym_w[i]),
      .out_cost (cost_w[i]),
      .out_prev (prev_w[i]),
      .out_res  (res_w[i])
    );
  end

  assign end_ctl = ctl_w[MAX_LEN];
  assign end_res = res_w[MAX_LEN];

endmodule
`default_nettype wire

FILE: hdl/edit_distance_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine
// Levenshtein distance with unit costs, computed by a systolic row of cells.
// ----------------------------------------------------------------------------
// Symbol items are taken one per cycle; busy stays low while strings load.
// The item that ends the second string raises busy; its result strobes on
// out_valid after passing the source, cell and output registers.
// The next item can be taken in the cycle in which the result is shown.
// Synchronous active-low reset clears all control state; stores need no clear.
module edit_distance_engine_unit #(
  parameter int MAX_LEN     = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [edd_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic                       in_second_string,
  input  wire logic                       in_last,
  input  wire logic                       in_empty_req,
  output logic                            out_valid,
  output logic [edd_pkg::DIST_W-1:0]      out_distance,
  output logic                            out_too_long
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = $clog2(MAX_LEN + 2);
  localparam int SW = (SYMBOL_BITS < edd_pkg::SYM_W) ? SYMBOL_BITS : edd_pkg::SYM_W;
  localparam int XW = (CW > edd_pkg::DIST_W) ? CW : edd_pkg::DIST_W;

  logic            acc;
  logic            busy_r, busy_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [LW-1:0]   end_len_r, end_len_nxt;
  logic            ovf_r, ovf_nxt;
  logic            closed_r, closed_nxt;
  logic            res_ovf_r, res_ovf_nxt;
  edd_pkg::ctl_t   src_ctl_r, src_ctl_nxt;
  logic [SW-1:0]   src_sym_r;
  logic [CW-1:0]   src_cost_r, src_cost_nxt;
  logic [CW-1:0]   src_prev_r, src_prev_nxt;
  logic [CW-1:0]   src_res_r, src_res_nxt;
  edd_pkg::bcast_t bc;
  logic [LW-1:0]   wr_idx;
  logic [LW-1:0]   base_len;
  logic [LW-1:0]   base_cnt;
  logic [LW-1:0]   upd_cnt;
  logic            upd;
  logic [SW-1:0]   sym;
  edd_pkg::ctl_t   end_ctl;
  logic [CW-1:0]   end_res;
  logic [XW-1:0]   res_x;
  logic            out_valid_r, out_valid_nxt;
  logic [edd_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic            too_long_r;

  assign acc = start && !busy_r;
  assign sym = in_symbol[SW-1:0];

  always_comb begin
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    end_len_nxt  = end_len_r;
    ovf_nxt      = ovf_r;
    closed_nxt   = closed_r;
    res_ovf_nxt  = res_ovf_r;
    busy_nxt     = busy_r;
    src_ctl_nxt  = '0;
    src_cost_nxt = src_cost_r;
    src_prev_nxt = src_prev_r;
    src_res_nxt  = src_res_r;
    bc           = '0;
    wr_idx       = len_r;
    base_len     = closed_r ? '0 : len_r;
    base_cnt     = closed_r ? cnt_r : '0;
    upd          = 1'b0;
    upd_cnt      = base_cnt;
    if (acc && !in_second_string) begin
      len_nxt    = base_len;
      ovf_nxt    = closed_r ? 1'b0 : ovf_r;
      closed_nxt = 1'b0;
      if (!in_empty_req) begin
        if (base_len < LW'(MAX_LEN)) begin
          bc.wr   = 1'b1;
          wr_idx  = base_len;
          len_nxt = base_len + LW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      if (in_last) begin
        bc.init     = 1'b1;
        closed_nxt  = 1'b1;
        cnt_nxt     = '0;
        end_len_nxt = len_nxt;
      end
    end else if (acc) begin
      if (!closed_r) begin
        bc.init     = 1'b1;
        end_len_nxt = len_r;
      end
      closed_nxt = 1'b1;
      upd        = !in_empty_req && (base_cnt < LW'(MAX_LEN));
      if (!in_empty_req && !upd) begin
        ovf_nxt = 1'b1;
      end
      if (upd) begin
        upd_cnt = base_cnt + LW'(1);
      end
      cnt_nxt           = upd_cnt;
      src_ctl_nxt.valid = upd || in_last;
      src_ctl_nxt.upd   = upd;
      src_ctl_nxt.fin   = in_last;
      src_cost_nxt      = CW'(upd_cnt);
      src_prev_nxt      = CW'(base_cnt);
      src_res_nxt       = CW'(upd_cnt);
      if (in_last) begin
        busy_nxt    = 1'b1;
        res_ovf_nxt = ovf_nxt;
        len_nxt     = '0;
        cnt_nxt     = '0;
        ovf_nxt     = 1'b0;
        closed_nxt  = 1'b0;
      end
    end
    out_valid_nxt = end_ctl.valid && end_ctl.fin;
    if (out_valid_nxt) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    res_x = XW'(end_res);
    if (res_x > XW'(edd_pkg::DIST_MAX)) begin
      dist_nxt = edd_pkg::DIST_W'(edd_pkg::DIST_MAX);
    end else begin
      dist_nxt = res_x[edd_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      len_r       <= '0;
      cnt_r       <= '0;
      end_len_r   <= '0;
      ovf_r       <= 1'b0;
      closed_r    <= 1'b0;
      res_ovf_r   <= 1'b0;
      src_ctl_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      end_len_r   <= end_len_nxt;
      ovf_r       <= ovf_nxt;
      closed_r    <= closed_nxt;
      res_ovf_r   <= res_ovf_nxt;
      src_ctl_r   <= src_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_sym_r  <= sym;
    src_cost_r <= src_cost_nxt;
    src_prev_r <= src_prev_nxt;
    src_res_r  <= src_res_nxt;
    dist_r     <= dist_nxt;
    too_long_r <= res_ovf_r;
  end

  edd_chain #(
    .MAX_LEN (MAX_LEN),
    .LW      (LW),
    .CW      (CW),
    .SW      (SW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .bc       (bc),
    .wr_idx   (wr_idx),
    .wr_sym   (sym),
    .end_len  (end_len_r),
    .src_ctl  (src_ctl_r),
    .src_sym  (src_sym_r),
    .src_cost (src_cost_r),
    .src_prev (src_prev_r),
    .src_res  (src_res_r),
    .end_ctl  (end_ctl),
    .end_res  (end_res)
  );

  assign busy         = busy_r;
  assign out_valid    = out_valid_r;
  assign out_distance = dist_r;
  assign out_too_long = too_long_r;

endmodule
`default_nettype wire

FILE: hdl/edd_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Edit distance engine checker
// Port-level checks of the busy window and the result strobe.
// ----------------------------------------------------------------------------
module edd_chk (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_second_string,
  input wire logic in_last,
  input wire logic out_valid
);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or out_valid set after reset");

  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_second_string && in_last |=> busy)
    else $error("busy not raised after the closing item");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

endmodule

bind edit_distance_engine_unit edd_chk u_edd_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_second_string (in_second_string),
  .in_last          (in_last),
  .out_valid        (out_valid)
);
`default_nettype wire

FILE: sim/edd_distance_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit distance checker
// Watches the item and result channels of the edit distance engine, keeps its
// own copy of the string store and cost row, predicts each distance and
// compares every strobed result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module edd_distance_checker #(
  parameter int MAX_LEN     = 256,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [edd_pkg::SYM_W-1:0]  in_symbol,
  input  logic                       in_second_string,
  input  logic                       in_last,
  input  logic                       in_empty_req,
  input  logic                       out_valid,
  input  logic [edd_pkg::DIST_W-1:0] out_distance,
  input  logic                       out_too_long,
  output int unsigned                err_count,
  output int unsigned                outstanding
);

  localparam logic [edd_pkg::SYM_W-1:0] SYM_MASK =
    edd_pkg::SYM_W'((64'd1 << SYMBOL_BITS) - 64'd1);

  typedef struct packed {
    logic [edd_pkg::DIST_W-1:0] distance;
    logic                       too_long;
  } edit_result_t;

  edit_result_t              pending_distances [$];
  logic [edd_pkg::SYM_W-1:0] first_syms [0:MAX_LEN-1];
  int unsigned               cost_row [0:MAX_LEN];
  int unsigned               first_len;
  int unsigned               second_len;
  bit                        truncated;
  bit                        first_done;
  int unsigned               mismatches;

  task clear_pair();
    first_len  = 0;
    second_len = 0;
    truncated  = 1'b0;
    first_done = 1'b0;
  endtask

  task open_row();
    for (int i = 0; i <= first_len; i++) cost_row[i] = i;
    first_done = 1'b1;
    second_len = 0;
  endtask

  task advance_row(input logic [edd_pkg::SYM_W-1:0] sym);
    int unsigned diag;
    int unsigned up;
    int unsigned sub;
    int unsigned best;
    diag = cost_row[0];
    cost_row[0] = second_len + 1;
    for (int i = 1; i <= first_len; i++) begin
      up   = cost_row[i];
      sub  = diag + ((first_syms[i-1] == sym) ? 0 : 1);
      best = up + 1;
      if (cost_row[i-1] + 1 < best) best = cost_row[i-1] + 1;
      if (sub < best) best = sub;
      cost_row[i] = best;
      diag = up;
    end
    second_len++;
  endtask

  task predict_item(input logic [edd_pkg::SYM_W-1:0] raw, input logic sec,
                    input logic lst, input logic emp);
    logic [edd_pkg::SYM_W-1:0] sym;
    edit_result_t              res;
    sym = raw & SYM_MASK;
    if (!sec) begin
      if (first_done) clear_pair();
      if (!emp) begin
        if (first_len < MAX_LEN) begin
          first_syms[first_len] = sym;
          first_len++;
        end else begin
          truncated = 1'b1;
        end
      end
      if (lst) open_row();
    end else begin
      if (!first_done) open_row();
      if (!emp) begin
        if (second_len < MAX_LEN) advance_row(sym);
        else truncated = 1'b1;
      end
      if (lst) begin
        res.distance = (cost_row[first_len] > edd_pkg::DIST_MAX)
                       ? edd_pkg::DIST_W'(edd_pkg::DIST_MAX)
                       : edd_pkg::DIST_W'(cost_row[first_len]);
        res.too_long = truncated;
        pending_distances.push_back(res);
        clear_pair();
      end
    end
  endtask

  initial begin
    mismatches = 0;
    clear_pair();
  end

  always @(posedge clk) begin
    edit_result_t want;
    if (!rst_n) begin
      clear_pair();
      pending_distances.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (pending_distances.size() == 0) begin
          $error("unexpected result: distance %0d, too_long %0b", out_distance, out_too_long);
          mismatches++;
        end else begin
          want = pending_distances.pop_front();
          if (out_distance !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, out_distance);
            mismatches++;
          end
          if (out_too_long !== want.too_long) begin
            $error("too_long: expected %0b, actual %0b", want.too_long, out_too_long);
            mismatches++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        predict_item(in_symbol, in_second_string, in_last, in_empty_req);
    end
    err_count   <= mismatches;
    outstanding <= pending_distances.size();
  end

endmodule

FILE: sim/edit_distance_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Drives string pairs into the engine: a directed set of corner cases, then
// random pairs with random pacing, long strings past the length limit and
// malformed sequences. A checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module edit_distance_engine_unit_tb;

  localparam int MAX_LEN      = 256;
  localparam int SYMBOL_BITS  = 8;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_ITEMS  = 85;

  logic                       clk;
  logic                       rst_n            = 1'b0;
  logic                       start            = 1'b0;
  logic [edd_pkg::SYM_W-1:0]  in_symbol        = '0;
  logic                       in_second_string = 1'b0;
  logic                       in_last          = 1'b0;
  logic                       in_empty_req     = 1'b0;
  logic                       busy;
  logic                       out_valid;
  logic [edd_pkg::DIST_W-1:0] out_distance;
  logic                       out_too_long;
  int unsigned                err_count;
  int unsigned                outstanding;
  int unsigned                cycle_count;
  int unsigned                idle_pct;
  int unsigned                items_sent;

  edit_distance_engine_unit #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_symbol        (in_symbol),
    .in_second_string (in_second_string),
    .in_last          (in_last),
    .in_empty_req     (in_empty_req),
    .out_valid        (out_valid),
    .out_distance     (out_distance),
    .out_too_long     (out_too_long)
  );

  edd_distance_checker #(
    .MAX_LEN     (MAX_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_symbol        (in_symbol),
    .in_second_string (in_second_string),
    .in_last          (in_last),
    .in_empty_req     (in_empty_req),
    .out_valid        (out_valid),
    .out_distance     (out_distance),
    .out_too_long     (out_too_long),
    .err_count        (err_count),
    .outstanding      (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("edit_distance_engine_unit: mismatch");
    $finish;
  end

  task send_item(input logic [edd_pkg::SYM_W-1:0] sym, input logic sec,
                 input logic lst, input logic emp);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_symbol        <= sym;
    in_second_string <= sec;
    in_last          <= lst;
    in_empty_req     <= emp;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task wait_for_distances();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // A closed string may end on an empty item instead of on its last symbol.
  task send_string(input logic sec, input int len, input bit close,
                   input logic [edd_pkg::SYM_W-1:0] base,
                   input logic [edd_pkg::SYM_W-1:0] mask);
    bit marker_end;
    marker_end = close && (len == 0 || $urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(edd_pkg::SYM_W'($urandom_range(0, 255)), sec, 1'b0, 1'b1);
        items_sent++;
      end
      send_item(base ^ (edd_pkg::SYM_W'($urandom_range(0, 255)) & mask), sec,
                close && !marker_end && (i == len - 1), 1'b0);
      items_sent++;
    end
    if (marker_end) begin
      send_item(edd_pkg::SYM_W'($urandom_range(0, 255)), sec, 1'b1, 1'b1);
      items_sent++;
    end
  endtask

  task random_pair();
    int                        kind;
    logic [edd_pkg::SYM_W-1:0] base;
    logic [edd_pkg::SYM_W-1:0] mask;
    kind = $urandom_range(0, 99);
    base = edd_pkg::SYM_W'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: begin
        mask = 8'h01;
      end
      1: begin
        mask = 8'h03;
      end
      default: begin
        mask = 8'hFF;
      end
    endcase
    if (kind < 75) begin
      send_string(1'b0, $urandom_range(0, 8), 1'b1, base, mask);
    end else if (kind < 85) begin
      send_string(1'b0, $urandom_range(1, 6), 1'b0, base, mask);
    end else if (kind < 93) begin
      send_string(1'b0, $urandom_range(0, 5), 1'b1, base, mask);
      send_string(1'b0, $urandom_range(0, 8), 1'b1, base, mask);
    end
    send_string(1'b1, $urandom_range(0, 8), 1'b1, base, mask);
  endtask

  initial begin
    idle_pct   = 13;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(8'h00, 1'b0, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b0, 1'b0);
    send_item(8'hAA, 1'b1, 1'b1, 1'b0);
    send_item(8'h12, 1'b0, 1'b0, 1'b0);
    send_item(8'h34, 1'b0, 1'b0, 1'b1);
    send_item(8'h12, 1'b1, 1'b0, 1'b0);
    send_item(8'h9C, 1'b1, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    wait_for_distances();
    send_item(8'h01, 1'b0, 1'b1, 1'b0);
    send_item(8'h02, 1'b0, 1'b0, 1'b0);
    send_item(8'h03, 1'b0, 1'b1, 1'b0);
    send_item(8'h02, 1'b1, 1'b0, 1'b0);
    send_item(8'h03, 1'b1, 1'b1, 1'b0);
    send_item(8'h80, 1'b0, 1'b0, 1'b0);
    send_item(8'h7F, 1'b0, 1'b1, 1'b0);
    send_item(8'hC3, 1'b1, 1'b1, 1'b1);
    wait_for_distances();

    send_string(1'b0, MAX_LEN + 1, 1'b1, edd_pkg::SYM_W'($urandom_range(0, 255)), 8'h03);
    send_string(1'b1, 1, 1'b1, edd_pkg::SYM_W'($urandom_range(0, 255)), 8'hFF);
    items_sent = 0;
    while (items_sent < PHASE_ITEMS) random_pair();
    wait_for_distances();

    idle_pct = 85;
    send_string(1'b0, 2, 1'b1, edd_pkg::SYM_W'($urandom_range(0, 255)), 8'hFF);
    send_string(1'b1, MAX_LEN + 1, 1'b1, edd_pkg::SYM_W'($urandom_range(0, 255)), 8'h01);
    items_sent = 0;
    while (items_sent < PHASE_ITEMS) random_pair();
    wait_for_distances();

    idle_pct   = 0;
    items_sent = 0;
    while (items_sent < PHASE_ITEMS) random_pair();

    wait_for_distances();
    repeat (MAX_LEN + 16) @(posedge clk);
    if (err_count == 0 && outstanding == 0) begin
      $display("edit_distance_engine_unit: match");
    end else begin
      $display("edit_distance_engine_unit: mismatch");
    end
    $finish;
  end

endmodule
